FILE: sv/line_rasterizer_assert.svh
// ---------------------------------------------------------------------------
// line_rasterizer assertion macros
// shared concurrent assertion forms, clocked on clock, reset by reset
// ---------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// implication in the same cycle
`define LR_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// implication in the next cycle
`define LR_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: sv/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg
// shared constants, types and helpers of the line rasterizer
// ---------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                      full;
      logic                      empty;
      logic [QUEUE_CNT_BITS-1:0] count;
   } lr_queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DRAW
   } lr_back_state_type;

   // packed command width: start point, four flags, two doubled deltas, major delta
   function automatic int lr_cmd_bits(input int coord_bits);
      return 5 * coord_bits + 6;
   endfunction

endpackage

`default_nettype wire

FILE: sv/lr_req_if.sv
// ---------------------------------------------------------------------------
// lr_req_if
// line segment channel: one beat carries a start point and an end point
// ---------------------------------------------------------------------------
`default_nettype none

interface lr_req_if #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

`default_nettype wire

FILE: sv/lr_rsp_if.sv
// ---------------------------------------------------------------------------
// lr_rsp_if
// pixel channel: one beat carries one pixel and its end-of-line mark
// ---------------------------------------------------------------------------
`default_nettype none

interface lr_rsp_if #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;

   modport source (output valid, output pixel_x, output pixel_y,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

FILE: sv/lr_queue.sv
// ---------------------------------------------------------------------------
// lr_queue
// small register fifo that carries setup commands from front to back
// ---------------------------------------------------------------------------
`default_nettype none

module lr_queue #(
   parameter int WIDTH = 36
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [WIDTH-1:0]            push_data,
   input  wire logic                        pop,
   output      logic [WIDTH-1:0]            pop_data,
   output      lr_pkg::lr_queue_status_type status
);
   import lr_pkg::*;

   localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] CNT_FULL = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

`default_nettype wire

FILE: sv/lr_front.sv
// ---------------------------------------------------------------------------
// lr_front
// accepts line segments, works out deltas, directions and major axis
// ---------------------------------------------------------------------------
`default_nettype none

module lr_front #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   lr_req_if.sink                                           req_chan,
   input  lr_pkg::lr_queue_status_type                      q_status,
   output logic                                             q_push,
   output logic [lr_pkg::lr_cmd_bits(COORD_BITS)-1:0]       q_push_data
);
   import lr_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic                  x_neg;
      logic                  y_neg;
      logic                  x_major;
      logic                  diag;
      logic [COORD_BITS:0]   twice_dx;
      logic [COORD_BITS:0]   twice_dy;
      logic [COORD_BITS-1:0] major;
   } cmd_type;

   cmd_type               cmd;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;

   // segment classification
   always_comb begin
      cmd.start_x  = req_chan.start_x;
      cmd.start_y  = req_chan.start_y;
      cmd.x_neg    = req_chan.start_x > req_chan.end_x;
      cmd.y_neg    = req_chan.start_y > req_chan.end_y;
      adx          = cmd.x_neg ? req_chan.start_x - req_chan.end_x
                               : req_chan.end_x - req_chan.start_x;
      ady          = cmd.y_neg ? req_chan.start_y - req_chan.end_y
                               : req_chan.end_y - req_chan.start_y;
      cmd.x_major  = adx >= ady;
      cmd.diag     = adx == ady;
      cmd.twice_dx = {adx, 1'b0};
      cmd.twice_dy = {ady, 1'b0};
      cmd.major    = cmd.x_major ? adx : ady;
   end

   // accept a beat whenever the queue has room
   assign req_chan.ready = !q_status.full;
   assign q_push         = req_chan.valid && !q_status.full;
   assign q_push_data    = cmd;

endmodule

`default_nettype wire

FILE: sv/lr_back.sv
// ---------------------------------------------------------------------------
// lr_back
// bresenham stepper: pops one command and, while the output register is free, emits one pixel per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module lr_back #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  lr_pkg::lr_queue_status_type                      q_status,
   output logic                                             q_pop,
   input  wire logic [lr_pkg::lr_cmd_bits(COORD_BITS)-1:0]  q_pop_data,
   lr_rsp_if.source                                         rsp_chan
);
   import lr_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic                  x_neg;
      logic                  y_neg;
      logic                  x_major;
      logic                  diag;
      logic [COORD_BITS:0]   twice_dx;
      logic [COORD_BITS:0]   twice_dy;
      logic [COORD_BITS-1:0] major;
   } cmd_type;

   function automatic logic [COORD_BITS-1:0] stepped(input logic [COORD_BITS-1:0] v,
                                                     input logic neg);
      return neg ? v - 1'b1 : v + 1'b1;
   endfunction

   cmd_type                     cmd;
   lr_back_state_type           state_ff, state_in;
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]       cur_y_ff, cur_y_in;
   logic signed [ERR_BITS-1:0]  err_ff, err_in;
   logic signed [ERR_BITS-1:0]  err_sub;
   logic [COORD_BITS:0]         steps_ff, steps_in;
   logic                        x_neg_ff, x_neg_in;
   logic                        y_neg_ff, y_neg_in;
   logic                        x_major_ff, x_major_in;
   logic                        diag_ff, diag_in;
   logic [COORD_BITS:0]         twice_dx_ff, twice_dx_in;
   logic [COORD_BITS:0]         twice_dy_ff, twice_dy_in;
   logic                        out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]       out_x_ff, out_x_in;
   logic [COORD_BITS-1:0]       out_y_ff, out_y_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_free;
   logic                        is_last;

   assign cmd      = q_pop_data;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign is_last  = (steps_ff == (COORD_BITS + 1)'(1));

   // next state, stepping and output register load
   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      err_sub      = '0;
      steps_in     = steps_ff;
      x_neg_in     = x_neg_ff;
      y_neg_in     = y_neg_ff;
      x_major_in   = x_major_ff;
      diag_in      = diag_ff;
      twice_dx_in  = twice_dx_ff;
      twice_dy_in  = twice_dy_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            // setup cycle: load the next command
            if (!q_status.empty) begin
               q_pop       = 1'b1;
               cur_x_in    = cmd.start_x;
               cur_y_in    = cmd.start_y;
               x_neg_in    = cmd.x_neg;
               y_neg_in    = cmd.y_neg;
               x_major_in  = cmd.x_major;
               diag_in     = cmd.diag;
               twice_dx_in = cmd.twice_dx;
               twice_dy_in = cmd.twice_dy;
               err_in      = $signed({2'b00, cmd.major});
               steps_in    = {1'b0, cmd.major} + (COORD_BITS + 1)'(1);
               state_in    = BACK_DRAW;
            end
         end
         BACK_DRAW: begin
            // emit the current pixel, then advance
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = cur_x_ff;
               out_y_in     = cur_y_ff;
               out_last_in  = is_last;
               steps_in     = steps_ff - 1'b1;
               if (is_last) begin
                  state_in = BACK_IDLE;
               end else if (diag_ff) begin
                  cur_x_in = stepped(cur_x_ff, x_neg_ff);
                  cur_y_in = stepped(cur_y_ff, y_neg_ff);
               end else if (x_major_ff) begin
                  cur_x_in = stepped(cur_x_ff, x_neg_ff);
                  err_sub  = err_ff - $signed({1'b0, twice_dy_ff});
                  err_in   = err_sub;
                  if (err_sub < 0) begin
                     cur_y_in = stepped(cur_y_ff, y_neg_ff);
                     err_in   = err_sub + $signed({1'b0, twice_dx_ff});
                  end
               end else begin
                  cur_y_in = stepped(cur_y_ff, y_neg_ff);
                  err_sub  = err_ff - $signed({1'b0, twice_dx_ff});
                  err_in   = err_sub;
                  if (err_sub < 0) begin
                     cur_x_in = stepped(cur_x_ff, x_neg_ff);
                     err_in   = err_sub + $signed({1'b0, twice_dy_ff});
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      err_ff      <= err_in;
      steps_ff    <= steps_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      x_major_ff  <= x_major_in;
      diag_ff     <= diag_in;
      twice_dx_ff <= twice_dx_in;
      twice_dy_ff <= twice_dy_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_x    = out_x_ff;
   assign rsp_chan.pixel_y    = out_y_ff;
   assign rsp_chan.last_pixel = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer
// bresenham line drawing: one segment in, one pixel beat per drawn pixel out
// ---------------------------------------------------------------------------
// req_chan takes one segment (start and end point) per beat; rsp_chan gives
// every pixel from start to end inclusive, last_pixel set on the end point.
// A segment yields max(|dx|,|dy|)+1 pixel beats.
// The front classifies a segment in the cycle it is accepted and puts the
// setup into a two-entry command queue; req_chan.ready is low only while
// that queue is full.
// The back stepper loads a command in its setup state, then emits one pixel
// per cycle while the output register is free, and takes no new command
// before the last pixel of the current one. A first pixel passes through the
// queue entry, the stepper position registers and the output register.
// When rsp_chan.ready is low the output register holds its pixel and the
// stepper waits; the front keeps accepting until the queue fills.
// Reset (synchronous, active high) empties the queue, returns the stepper to
// idle and drops rsp_chan.valid.
// ---------------------------------------------------------------------------
`default_nettype none
`include "line_rasterizer_assert.svh"

module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lr_req_if.sink     req_chan,
   lr_rsp_if.source   rsp_chan
);
   import lr_pkg::*;

   localparam int CMD_BITS = lr_cmd_bits(COORD_BITS);
   localparam logic [QUEUE_CNT_BITS-1:0] CNT_MAX = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   lr_queue_status_type  q_status;
   logic                 q_push;
   logic                 q_pop;
   logic [CMD_BITS-1:0]  q_push_data;
   logic [CMD_BITS-1:0]  q_pop_data;

   // segment setup
   lr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_chan    (req_chan),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // command queue
   lr_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // pixel stepper
   lr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .q_pop_data (q_pop_data),
      .rsp_chan   (rsp_chan)
   );

   // queue and stepper consistency
   `LR_ASSERT_SAME(a_no_push_full, q_push, !q_status.full, "push into full queue")
   `LR_ASSERT_SAME(a_no_pop_empty, q_pop, !q_status.empty, "pop from empty queue")
   `LR_ASSERT_SAME(a_count_bound, 1'b1, q_status.count <= CNT_MAX, "queue overfilled")
   `LR_ASSERT_NEXT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid, "beat dropped")

endmodule

`default_nettype wire

FILE: verif/line_rasterizer_tb.sv
// ---------------------------------------------------------------------------
// line_rasterizer_tb
// self-checking bench for the bresenham line rasterizer: a table of directed
// segments, then random segments under several idling mixes and one long
// output hold; every pixel beat is checked against a typed pixel or an in-bench stepper model
// ---------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB               = lr_pkg::COORD_BITS_DEFAULT;
   localparam int RANDOM_PER_PHASE = 48;
   localparam int PRESSURE_ITEMS   = 8;
   localparam int HOLD_CYCLES      = 300;
   localparam int STALL_LIMIT      = 4000;
   localparam int MAX_REPORTS      = 10;
   localparam int TAIL_CYCLES      = 16;

   typedef logic [CB-1:0] coord_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } segment_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   typedef struct packed {
      segment_type seg;
      logic        typed;
      pixel_type   golden;
   } directed_row_type;

   logic clock;
   logic reset;

   lr_req_if #(.COORD_BITS(CB)) req_bus ();
   lr_rsp_if #(.COORD_BITS(CB)) rsp_bus ();

   line_rasterizer #(.COORD_BITS(CB)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // stepper model state
   coord_type            walk_x;
   coord_type            walk_y;
   logic signed [CB+1:0] bres_err;
   logic [CB:0]          pixels_left;
   logic                 x_down;
   logic                 y_down;
   logic [CB:0]          dx2;
   logic [CB:0]          dy2;
   logic                 x_major;

   pixel_type pending_pixels [$];

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_request;
   int stalled_cycles = 0;
   int failures = 0;

   // directed segments; single points carry their pixel typed in
   directed_row_type directed_rows [0:23] = '{
      '{'{0, 0, 0, 0},     1, '{0, 0, 1}},
      '{'{63, 63, 63, 63}, 1, '{63, 63, 1}},
      '{'{45, 12, 45, 12}, 1, '{45, 12, 1}},
      '{'{0, 0, 63, 0},    0, '{0, 0, 0}},
      '{'{63, 0, 0, 0},    0, '{0, 0, 0}},
      '{'{0, 0, 0, 63},    0, '{0, 0, 0}},
      '{'{5, 63, 5, 0},    0, '{0, 0, 0}},
      '{'{0, 0, 63, 63},   0, '{0, 0, 0}},
      '{'{63, 0, 0, 63},   0, '{0, 0, 0}},
      '{'{63, 63, 0, 0},   0, '{0, 0, 0}},
      '{'{0, 63, 63, 0},   0, '{0, 0, 0}},
      '{'{21, 42, 42, 21}, 0, '{0, 0, 0}},
      '{'{42, 21, 21, 42}, 0, '{0, 0, 0}},
      '{'{10, 20, 40, 27}, 0, '{0, 0, 0}},
      '{'{40, 27, 10, 20}, 0, '{0, 0, 0}},
      '{'{3, 60, 9, 1},    0, '{0, 0, 0}},
      '{'{9, 1, 3, 60},    0, '{0, 0, 0}},
      '{'{0, 0, 63, 1},    0, '{0, 0, 0}},
      '{'{0, 0, 1, 63},    0, '{0, 0, 0}},
      '{'{0, 0, 63, 62},   0, '{0, 0, 0}},
      '{'{62, 63, 0, 0},   0, '{0, 0, 0}},
      '{'{30, 30, 31, 31}, 0, '{0, 0, 0}},
      '{'{30, 30, 31, 30}, 0, '{0, 0, 0}},
      '{'{1, 2, 63, 32},   0, '{0, 0, 0}}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic coord_type step_coord(coord_type v, logic down);
      return down ? v - 1'b1 : v + 1'b1;
   endfunction

   // walk one segment and queue every pixel it yields
   function automatic void rasterize_segment(segment_type s);
      coord_type adx;
      coord_type ady;
      coord_type major;
      pixel_type px;
      adx = (s.sx > s.ex) ? s.sx - s.ex : s.ex - s.sx;
      ady = (s.sy > s.ey) ? s.sy - s.ey : s.ey - s.sy;
      major = (adx >= ady) ? adx : ady;
      walk_x = s.sx;
      walk_y = s.sy;
      x_down = s.sx > s.ex;
      y_down = s.sy > s.ey;
      dx2 = {adx, 1'b0};
      dy2 = {ady, 1'b0};
      x_major = adx >= ady;
      bres_err = $signed({2'b00, major});
      pixels_left = {1'b0, major} + 1'b1;
      while (pixels_left != 0) begin
         px.x = walk_x;
         px.y = walk_y;
         px.last = (pixels_left == 1);
         pending_pixels.push_back(px);
         pixels_left = pixels_left - 1'b1;
         if (!px.last) begin
            if (adx == ady) begin
               walk_x = step_coord(walk_x, x_down);
               walk_y = step_coord(walk_y, y_down);
            end else if (x_major) begin
               walk_x = step_coord(walk_x, x_down);
               bres_err = bres_err - $signed({1'b0, dy2});
               if (bres_err < 0) begin
                  walk_y = step_coord(walk_y, y_down);
                  bres_err = bres_err + $signed({1'b0, dx2});
               end
            end else begin
               walk_y = step_coord(walk_y, y_down);
               bres_err = bres_err - $signed({1'b0, dx2});
               if (bres_err < 0) begin
                  walk_x = step_coord(walk_x, x_down);
                  bres_err = bres_err + $signed({1'b0, dy2});
               end
            end
         end
      end
   endfunction

   // mix of full-range, short, axis-aligned, diagonal and single-point segments
   function automatic segment_type random_segment();
      segment_type s;
      int kind;
      int mode;
      int lo;
      int hi;
      int room_x;
      int room_y;
      int d;
      logic go_left;
      logic go_down;
      kind = $urandom_range(9);
      s.sx = coord_type'($urandom);
      s.sy = coord_type'($urandom);
      s.ex = coord_type'($urandom);
      s.ey = coord_type'($urandom);
      if (kind >= 5 && kind < 8) begin
         lo = (s.sx < 7) ? 0 : s.sx - 7;
         hi = (s.sx > 56) ? 63 : s.sx + 7;
         s.ex = coord_type'($urandom_range(hi, lo));
         lo = (s.sy < 7) ? 0 : s.sy - 7;
         hi = (s.sy > 56) ? 63 : s.sy + 7;
         s.ey = coord_type'($urandom_range(hi, lo));
      end else if (kind >= 8) begin
         mode = $urandom_range(3);
         case (mode)
            0: begin
               s.ey = s.sy;
            end
            1: begin
               s.ex = s.sx;
            end
            2: begin
               go_left = 1'($urandom_range(1));
               go_down = 1'($urandom_range(1));
               room_x = go_left ? s.sx : 63 - s.sx;
               room_y = go_down ? s.sy : 63 - s.sy;
               d = $urandom_range((room_x < room_y) ? room_x : room_y);
               s.ex = coord_type'(go_left ? s.sx - d : s.sx + d);
               s.ey = coord_type'(go_down ? s.sy - d : s.sy + d);
            end
            default: begin
               s.ex = s.sx;
               s.ey = s.sy;
            end
         endcase
      end
      return s;
   endfunction

   // offer one segment from a falling edge, return at the falling edge after its beat
   task automatic send_segment(segment_type s, logic typed, pixel_type golden);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.start_x <= s.sx;
      req_bus.start_y <= s.sy;
      req_bus.end_x   <= s.ex;
      req_bus.end_y   <= s.ey;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (typed) begin
         pending_pixels.push_back(golden);
      end else begin
         rasterize_segment(s);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic note_failure(string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%t: %s", $realtime, what);
   endtask

   // pixel receiver: random stalls plus one long hold
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // pixel checker and stall counter
   initial begin
      pixel_type want;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if ((req_bus.valid && req_bus.ready) ||
                (rsp_bus.valid && rsp_bus.ready && pending_pixels.size() != 0)) begin
               stalled_cycles = 0;
            end else begin
               stalled_cycles++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (pending_pixels.size() == 0) begin
                  note_failure($sformatf("pixel beat with none expected: x=%0d y=%0d last=%0b",
                     rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last_pixel));
               end else begin
                  want = pending_pixels.pop_front();
                  if (rsp_bus.pixel_x !== want.x || rsp_bus.pixel_y !== want.y ||
                      rsp_bus.last_pixel !== want.last) begin
                     note_failure($sformatf(
                        "pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        want.x, want.y, want.last,
                        rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last_pixel));
                  end
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus
   initial begin
      int i;
      int phase;
      pixel_type no_pixel;
      no_pixel = '0;
      reset = 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.end_x   <= '0;
      req_bus.end_y   <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[row]) begin
         send_segment(directed_rows[row].seg, directed_rows[row].typed,
                      directed_rows[row].golden);
      end
      wait_drained();

      // random segments: no idling, sender idle, receiver stalling, both
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 28 : 0;
         recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 28 : 0;
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_segment(random_segment(), 1'b0, no_pixel);
         end
         wait_drained();
      end

      // long output hold while segments keep coming, so the input backs up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      for (i = 0; i < PRESSURE_ITEMS; i++) begin
         send_segment(random_segment(), 1'b0, no_pixel);
      end
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && pending_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
